/* design/i2c_slave_byte_fsm_with_fifos_defines.svh */
// ----------------------------------------------------------------------------
// I2C slave byte sequencer - assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef I2C_SLAVE_BYTE_FSM_WITH_FIFOS_DEFINES_SVH
`define I2C_SLAVE_BYTE_FSM_WITH_FIFOS_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define I2CS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c slave check failed");

// Next-cycle implication, disabled during reset
`define I2CS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c slave check failed");

`endif

/* design/i2cs_pkg.sv */
// ----------------------------------------------------------------------------
// I2C slave byte sequencer - package
// Request and result types, buffer sizes, event, phase, action and status codes.
// ----------------------------------------------------------------------------
package i2cs_pkg;

  // Buffer sizes and derived widths
  localparam int TX_DEPTH = 16;
  localparam int RX_DEPTH = 16;
  localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

  // Own address after reset
  localparam logic [6:0] SLAVE_ADDR_RESET = 7'h18;

  // Event codes
  localparam logic [2:0] FN_START = 3'd0;
  localparam logic [2:0] FN_STOP  = 3'd1;
  localparam logic [2:0] FN_SHIFT = 3'd2;
  localparam logic [2:0] FN_PUSH  = 3'd3;
  localparam logic [2:0] FN_POP   = 3'd4;

  // Bus actions
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_ACK       = 3'd1;
  localparam logic [2:0] ACT_SHIFT_OUT = 3'd2;
  localparam logic [2:0] ACT_READ_ACK  = 3'd3;
  localparam logic [2:0] ACT_READ_BYTE = 3'd4;
  localparam logic [2:0] ACT_RELEASE   = 3'd5;
  localparam logic [2:0] ACT_HOLD      = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TX_FULL    = 2'd1;
  localparam logic [1:0] ST_RX_EMPTY   = 2'd2;
  localparam logic [1:0] ST_RX_OVERRUN = 2'd3;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE          = 3'd0;
  localparam logic [2:0] PH_CHECK_ADDRESS = 3'd1;
  localparam logic [2:0] PH_SEND          = 3'd2;
  localparam logic [2:0] PH_REQ_REPLY     = 3'd3;
  localparam logic [2:0] PH_CHECK_REPLY   = 3'd4;
  localparam logic [2:0] PH_REQ_DATA      = 3'd5;
  localparam logic [2:0] PH_GET_DATA      = 3'd6;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] bus_byte;
    logic [7:0] host_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] shift_out_byte;
    logic [7:0] popped_byte;
    logic [1:0] status;
    logic       rx_has_data;
  } rsp_t;

endpackage

/* design/i2c_slave_byte_fsm_with_fifos.sv */
// ----------------------------------------------------------------------------
// I2C slave byte sequencer with transmit and receive ring buffers
// Byte-level slave control, host push/pop, one result per request.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless out_ready stalls the results; each
// accepted request returns one result via the read stage and the output
// register. This rate holds as each request makes at most one access to each
// ring buffer, and each buffer is a synchronous memory with one write and one
// read port. Buffer contents need no clearing after reset; the fill counts
// keep unwritten entries from ever being read. The own address is written
// through cfg_wr_en/cfg_wr_data; the user must do so only while no request is in flight (not enforced).
module i2c_slave_byte_fsm_with_fifos (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  i2cs_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output i2cs_pkg::rsp_t out_data,
  input  logic          cfg_wr_en,
  input  logic [6:0]    cfg_wr_data
);
  import i2cs_pkg::*;

  // Control state
  logic [6:0]          slave_addr_r;
  logic [2:0]          phase_r, phase_nxt;
  logic [TX_PTR_W-1:0] tx_wr_ptr_r, tx_rd_ptr_r;
  logic [RX_PTR_W-1:0] rx_wr_ptr_r, rx_rd_ptr_r;
  logic [TX_CNT_W-1:0] tx_cnt_r, tx_cnt_nxt;
  logic [RX_CNT_W-1:0] rx_cnt_r, rx_cnt_nxt;

  // Ring buffer memories
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_rdata_r, rx_rdata_r;

  // Read stage
  logic       s1_valid_r;
  logic [2:0] s1_act_r;
  logic [1:0] s1_status_r;
  logic       s1_has_r;
  logic       s1_sent_r;
  logic       s1_popped_r;

  // Output register
  logic out_valid_r;
  rsp_t out_data_r;

  // Decode of the request in hand
  logic       accept;
  logic       s1_move;
  logic [2:0] act;
  logic [1:0] status;
  logic       tx_push, tx_pop, rx_push, rx_pop;
  logic       try_send;
  logic       tx_full, tx_empty, rx_full, rx_empty;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign accept   = in_valid && in_ready;

  assign tx_full  = (tx_cnt_r == TX_CNT_W'(TX_DEPTH));
  assign tx_empty = (tx_cnt_r == '0);
  assign rx_full  = (rx_cnt_r == RX_CNT_W'(RX_DEPTH));
  assign rx_empty = (rx_cnt_r == '0);

  // Sequencer step
  always_comb begin
    phase_nxt = phase_r;
    act       = ACT_NONE;
    status    = ST_OK;
    tx_push   = 1'b0;
    tx_pop    = 1'b0;
    rx_push   = 1'b0;
    rx_pop    = 1'b0;
    try_send  = 1'b0;
    case (in_data.func)
      FN_START: begin
        phase_nxt = PH_CHECK_ADDRESS;
      end
      FN_STOP: begin
        phase_nxt = PH_IDLE;
        act       = ACT_RELEASE;
      end
      FN_SHIFT: begin
        case (phase_r)
          PH_CHECK_ADDRESS: begin
            if (in_data.bus_byte == 8'd0 || in_data.bus_byte[7:1] == slave_addr_r) begin
              phase_nxt = in_data.bus_byte[0] ? PH_SEND : PH_REQ_DATA;
              act       = ACT_ACK;
            end else begin
              phase_nxt = PH_IDLE;
              act       = ACT_RELEASE;
            end
          end
          PH_CHECK_REPLY: begin
            if (in_data.bus_byte != 8'd0) begin
              phase_nxt = PH_IDLE;
              act       = ACT_RELEASE;
            end else begin
              try_send = 1'b1;
            end
          end
          PH_SEND: begin
            try_send = 1'b1;
          end
          PH_REQ_REPLY: begin
            phase_nxt = PH_CHECK_REPLY;
            act       = ACT_READ_ACK;
          end
          PH_REQ_DATA: begin
            phase_nxt = PH_GET_DATA;
            act       = ACT_READ_BYTE;
          end
          PH_GET_DATA: begin
            if (!rx_full) begin
              rx_push = 1'b1;
            end else begin
              status = ST_RX_OVERRUN;
            end
            phase_nxt = PH_REQ_DATA;
            act       = ACT_ACK;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
        // Send the oldest queued byte, or hold the clock when none is queued
        if (try_send) begin
          if (!tx_empty) begin
            tx_pop    = 1'b1;
            phase_nxt = PH_REQ_REPLY;
            act       = ACT_SHIFT_OUT;
          end else begin
            phase_nxt = PH_SEND;
            act       = ACT_HOLD;
          end
        end
      end
      FN_PUSH: begin
        if (!tx_full) begin
          tx_push = 1'b1;
        end else begin
          status = ST_TX_FULL;
        end
      end
      FN_POP: begin
        if (!rx_empty) begin
          rx_pop = 1'b1;
        end else begin
          status = ST_RX_EMPTY;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // Fill counts after the step
  always_comb begin
    tx_cnt_nxt = tx_cnt_r;
    rx_cnt_nxt = rx_cnt_r;
    if (tx_push) tx_cnt_nxt = tx_cnt_r + 1'b1;
    if (tx_pop)  tx_cnt_nxt = tx_cnt_r - 1'b1;
    if (rx_push) rx_cnt_nxt = rx_cnt_r + 1'b1;
    if (rx_pop)  rx_cnt_nxt = rx_cnt_r - 1'b1;
  end

  // Control registers: advance on each accepted request; own address on cfg_wr_en
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_ADDR_RESET;
      phase_r      <= PH_IDLE;
      tx_wr_ptr_r  <= '0;
      tx_rd_ptr_r  <= '0;
      rx_wr_ptr_r  <= '0;
      rx_rd_ptr_r  <= '0;
      tx_cnt_r     <= '0;
      rx_cnt_r     <= '0;
    end else begin
      if (cfg_wr_en) slave_addr_r <= cfg_wr_data;
      if (accept) begin
        phase_r  <= phase_nxt;
        tx_cnt_r <= tx_cnt_nxt;
        rx_cnt_r <= rx_cnt_nxt;
        if (tx_push) begin
          tx_wr_ptr_r <= (tx_wr_ptr_r == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_wr_ptr_r + 1'b1;
        end
        if (tx_pop) begin
          tx_rd_ptr_r <= (tx_rd_ptr_r == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_rd_ptr_r + 1'b1;
        end
        if (rx_push) begin
          rx_wr_ptr_r <= (rx_wr_ptr_r == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_wr_ptr_r + 1'b1;
        end
        if (rx_pop) begin
          rx_rd_ptr_r <= (rx_rd_ptr_r == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_rd_ptr_r + 1'b1;
        end
      end
    end
  end

  // Transmit buffer: write on push, registered read at the head; the read
  // data holds while the read stage is stalled
  always_ff @(posedge clk) begin
    if (accept && tx_push) tx_mem[tx_wr_ptr_r] <= in_data.host_byte;
    if (accept) tx_rdata_r <= tx_mem[tx_rd_ptr_r];
  end

  // Receive buffer: write on stored byte, registered read at the head
  always_ff @(posedge clk) begin
    if (accept && rx_push) rx_mem[rx_wr_ptr_r] <= in_data.bus_byte;
    if (accept) rx_rdata_r <= rx_mem[rx_rd_ptr_r];
  end

  // Read stage: hold the decoded result while the buffer read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act_r    <= act;
      s1_status_r <= status;
      s1_has_r    <= (rx_cnt_nxt != '0);
      s1_sent_r   <= tx_pop;
      s1_popped_r <= rx_pop;
    end
  end

  // Output register: load from the read stage, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.bus_action     <= s1_act_r;
      out_data_r.shift_out_byte <= s1_sent_r ? tx_rdata_r : 8'd0;
      out_data_r.popped_byte    <= s1_popped_r ? rx_rdata_r : 8'd0;
      out_data_r.status         <= s1_status_r;
      out_data_r.rx_has_data    <= s1_has_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/i2cs_checker.sv */
// ----------------------------------------------------------------------------
// I2C slave byte sequencer - port checker
// Watches the result channel of the top level and checks its consistency.
// ----------------------------------------------------------------------------
`include "i2c_slave_byte_fsm_with_fifos_defines.svh"

module i2cs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input i2cs_pkg::rsp_t out_data
);
  import i2cs_pkg::*;

  // A stalled result holds
  `I2CS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // A byte is driven only with a shift-out action
  `I2CS_ASSERT_SAME(a_sent_only_shift, clk, rst_n, out_valid && out_data.bus_action != ACT_SHIFT_OUT, out_data.shift_out_byte == 8'd0)

  // A failed request returns no popped byte
  `I2CS_ASSERT_SAME(a_pop_only_ok, clk, rst_n, out_valid && out_data.status != ST_OK, out_data.popped_byte == 8'd0)

  // A rejected push causes no bus action
  `I2CS_ASSERT_SAME(a_push_no_bus, clk, rst_n, out_valid && out_data.status == ST_TX_FULL, out_data.bus_action == ACT_NONE)

endmodule

bind i2c_slave_byte_fsm_with_fifos i2cs_checker u_i2cs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
